// ===== hw/rtl/tmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the triggered multichannel capture block.
// Used by the lane, bank, top level and checker files; depends on nothing.
package tmc_pkg;

   // Field widths fixed by the block's interface
   localparam int SAMPLE_W   = 32;
   localparam int CHAN_W     = 2;
   localparam int MODE_W     = 2;
   localparam int ENABLE_W   = 4;
   localparam int LIMIT_W    = 11;
   localparam int REQ_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // One lane per channel port, one bank per low address code
   localparam int NUM_LANES = 4;
   localparam int BANK_W    = 2;
   localparam int NUM_BANKS = 4;
   localparam int POS_W     = 2;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ARM   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_STOP  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_READ  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

   // Capture state codes, also reported as status
   localparam logic [STATUS_W-1:0] ST_IDLE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_WAIT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CAPT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DONE = 2'd3;

   // Trigger modes
   localparam logic [MODE_W-1:0] MODE_IMMEDIATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ANY       = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RISING    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FALLING   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_LIMIT     = 2'd3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   // One captured buffer entry
   typedef struct packed {
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] value;
   } entry_type;

endpackage

// ===== hw/rtl/triggered_multichannel_capture.sv =====
`timescale 1ns / 1ps
// Triggered multichannel capture: top level with control, lanes and buffer banks.
// Depends on tmc_pkg, tmc_lane and tmc_bank.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one transaction per command:
//   sample tick, arm, stop, read entry or clear count, with the trigger and
//   four channel samples and a read index. Every transaction yields exactly one
//   response transaction (rsp_valid/rsp_ready) with the status and entry count
//   after the command, plus the buffer entry for a valid read.
//   Registers are written through csr_write_en/csr_index/csr_write_data while
//   no transaction is outstanding.
//   Latency: the response is valid the cycle after the request is taken.
//   Throughput: one transaction per clock unless stalled. A capture tick stores
//   up to four entries in that cycle, one per lane, each into its own bank chosen
//   by the low two bits of the entry address, so the buffer never needs more than
//   one write per bank per cycle; a read uses the one registered bank read port.
//   Reset (synchronous) returns to idle with a zero count and default
//   registers; buffer contents are not cleared, and only entries below the
//   count can be read. When the receiver stalls, the response register holds
//   its transaction and req_ready drops until it is taken.
module triggered_multichannel_capture #(
   parameter int SAMPLE_DEPTH = 1024,
   localparam int IDX_W = $clog2(SAMPLE_DEPTH),
   localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_write_en,
   input  logic [tmc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tmc_pkg::CSR_DATA_W-1:0]       csr_write_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tmc_pkg::REQ_W-1:0]            req_type,
   input  logic signed [tmc_pkg::SAMPLE_W-1:0]  req_trigger_sample,
   input  logic signed [tmc_pkg::SAMPLE_W-1:0]  req_ch0_sample,
   input  logic signed [tmc_pkg::SAMPLE_W-1:0]  req_ch1_sample,
   input  logic signed [tmc_pkg::SAMPLE_W-1:0]  req_ch2_sample,
   input  logic signed [tmc_pkg::SAMPLE_W-1:0]  req_ch3_sample,
   input  logic [IDX_W-1:0]                     req_read_index,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tmc_pkg::STATUS_W-1:0]         rsp_capture_status,
   output logic [CNT_W-1:0]                     rsp_sample_count,
   output logic [tmc_pkg::CHAN_W-1:0]           rsp_read_channel,
   output logic signed [tmc_pkg::SAMPLE_W-1:0]  rsp_read_value,
   output logic                                 rsp_read_valid
);

   localparam int ROWS  = (SAMPLE_DEPTH + tmc_pkg::NUM_BANKS - 1) / tmc_pkg::NUM_BANKS;
   localparam int RW    = IDX_W - tmc_pkg::BANK_W;
   localparam int CMP_W = (CNT_W > tmc_pkg::LIMIT_W) ? CNT_W : tmc_pkg::LIMIT_W;
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(SAMPLE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SAMPLE_DEPTH);

   // Configuration registers
   logic [tmc_pkg::MODE_W-1:0]        trigger_mode_ff;
   logic signed [tmc_pkg::SAMPLE_W-1:0] trigger_threshold_ff;
   logic [tmc_pkg::ENABLE_W-1:0]      channel_enable_ff;
   logic [tmc_pkg::LIMIT_W-1:0]       capture_limit_ff;

   // Control state
   logic [tmc_pkg::STATUS_W-1:0] state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic signed [tmc_pkg::SAMPLE_W-1:0] prev_trig_ff, prev_trig_in;

   // Response register
   logic                         p_valid_ff;
   logic [tmc_pkg::STATUS_W-1:0] p_status_ff;
   logic [CNT_W-1:0]             p_count_ff;
   logic                         p_rvalid_ff;
   logic [tmc_pkg::BANK_W-1:0]   p_bank_ff;

   logic                 accept;
   logic                 is_tick;
   logic                 is_read;
   logic [CMP_W-1:0]     limit_cmp;
   logic [CNT_W-1:0]     lim_eff;
   logic [CNT_W-1:0]     room;
   logic                 below_lim;
   logic                 tick_capt;
   logic                 now_hi;
   logic                 last_hi;
   logic                 rd_hit;
   logic [CNT_W-1:0]     nwr;

   logic signed [tmc_pkg::SAMPLE_W-1:0] lane_sample [tmc_pkg::NUM_LANES];
   logic                    lane_valid [tmc_pkg::NUM_LANES];
   logic [IDX_W-1:0]        lane_addr  [tmc_pkg::NUM_LANES];
   tmc_pkg::entry_type      lane_entry [tmc_pkg::NUM_LANES];
   logic [tmc_pkg::NUM_LANES-1:0] lane_valid_vec;

   logic                    bank_we    [tmc_pkg::NUM_BANKS];
   logic [RW-1:0]           bank_wrow  [tmc_pkg::NUM_BANKS];
   tmc_pkg::entry_type      bank_wdata [tmc_pkg::NUM_BANKS];
   logic                    bank_re    [tmc_pkg::NUM_BANKS];
   tmc_pkg::entry_type      bank_rdata [tmc_pkg::NUM_BANKS];
   tmc_pkg::entry_type      rd_sel;

   // Handshake: the response register frees when empty or being taken
   assign req_ready = !p_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_tick   = (req_type == tmc_pkg::REQ_TICK);
   assign is_read   = (req_type == tmc_pkg::REQ_READ);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_mode_ff      <= tmc_pkg::MODE_IMMEDIATE;
         trigger_threshold_ff <= '0;
         channel_enable_ff    <= '0;
         capture_limit_ff     <= tmc_pkg::LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tmc_pkg::CSR_TRIGGER_MODE: begin
               trigger_mode_ff <= csr_write_data[tmc_pkg::MODE_W-1:0];
            end
            tmc_pkg::CSR_TRIGGER_THRESHOLD: begin
               trigger_threshold_ff <= csr_write_data[tmc_pkg::SAMPLE_W-1:0];
            end
            tmc_pkg::CSR_CHANNEL_ENABLE: begin
               channel_enable_ff <= csr_write_data[tmc_pkg::ENABLE_W-1:0];
            end
            tmc_pkg::CSR_CAPTURE_LIMIT: begin
               capture_limit_ff <= csr_write_data[tmc_pkg::LIMIT_W-1:0];
            end
         endcase
      end
   end

   // Effective limit, clipped to the buffer depth
   assign limit_cmp = CMP_W'(capture_limit_ff);
   assign lim_eff   = (limit_cmp > DEPTH_CMP) ? DEPTH_CNT : limit_cmp[CNT_W-1:0];
   assign below_lim = (count_ff < lim_eff);
   assign room      = lim_eff - count_ff;
   assign tick_capt = accept && is_tick && (state_ff == tmc_pkg::ST_CAPT) && below_lim;

   // Trigger level tests against the threshold
   assign now_hi  = (req_trigger_sample >= trigger_threshold_ff);
   assign last_hi = (prev_trig_ff >= trigger_threshold_ff);

   // Capture lanes, one per channel
   assign lane_sample[0] = req_ch0_sample;
   assign lane_sample[1] = req_ch1_sample;
   assign lane_sample[2] = req_ch2_sample;
   assign lane_sample[3] = req_ch3_sample;

   for (genvar l = 0; l < tmc_pkg::NUM_LANES; l++) begin : g_lane
      tmc_lane #(
         .LANE  (l),
         .CNT_W (CNT_W),
         .IDX_W (IDX_W)
      ) u_lane (
         .tick_capt (tick_capt),
         .enable    (channel_enable_ff),
         .count     (count_ff),
         .room      (room),
         .sample    (lane_sample[l]),
         .wr_valid  (lane_valid[l]),
         .wr_addr   (lane_addr[l]),
         .wr_entry  (lane_entry[l])
      );
      assign lane_valid_vec[l] = lane_valid[l];
   end

   assign nwr = CNT_W'($countones(lane_valid_vec));

   // Merge: route each lane's entry to the bank named by its address low bits
   for (genvar b = 0; b < tmc_pkg::NUM_BANKS; b++) begin : g_route
      always_comb begin
         bank_we[b]    = 1'b0;
         bank_wrow[b]  = '0;
         bank_wdata[b] = '0;
         for (int l = 0; l < tmc_pkg::NUM_LANES; l++) begin
            if (lane_valid[l] &&
                (lane_addr[l][tmc_pkg::BANK_W-1:0] == tmc_pkg::BANK_W'(b))) begin
               bank_we[b]    = 1'b1;
               bank_wrow[b]  = lane_addr[l][IDX_W-1:tmc_pkg::BANK_W];
               bank_wdata[b] = lane_entry[l];
            end
         end
      end

      assign bank_re[b] = accept && is_read && rd_hit &&
                          (req_read_index[tmc_pkg::BANK_W-1:0] == tmc_pkg::BANK_W'(b));

      tmc_bank #(
         .ROWS (ROWS),
         .RW   (RW)
      ) u_bank (
         .clock    (clock),
         .wr_en    (bank_we[b]),
         .wr_row   (bank_wrow[b]),
         .wr_entry (bank_wdata[b]),
         .rd_en    (bank_re[b]),
         .rd_row   (req_read_index[IDX_W-1:tmc_pkg::BANK_W]),
         .rd_entry (bank_rdata[b])
      );
   end

   // A read hits only below the count
   assign rd_hit = (CNT_W'(req_read_index) < count_ff) &&
                   (CNT_W'(req_read_index) < DEPTH_CNT);

   // Command decode and capture state machine
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      prev_trig_in = prev_trig_ff;
      if (accept) begin
         unique case (req_type)
            tmc_pkg::REQ_TICK: begin
               unique case (state_ff)
                  tmc_pkg::ST_CAPT: begin
                     if (below_lim) begin
                        count_in = count_ff + nwr;
                     end else begin
                        state_in = tmc_pkg::ST_DONE;
                     end
                  end
                  tmc_pkg::ST_WAIT: begin
                     prev_trig_in = req_trigger_sample;
                     if (trigger_mode_ff == tmc_pkg::MODE_IMMEDIATE) begin
                        state_in = tmc_pkg::ST_CAPT;
                     end else if (now_hi != last_hi) begin
                        if ((trigger_mode_ff == tmc_pkg::MODE_ANY) ||
                            (trigger_mode_ff == tmc_pkg::MODE_RISING && now_hi) ||
                            (trigger_mode_ff == tmc_pkg::MODE_FALLING && !now_hi)) begin
                           state_in = tmc_pkg::ST_CAPT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            tmc_pkg::REQ_ARM: begin
               count_in     = '0;
               prev_trig_in = req_trigger_sample;
               state_in     = (trigger_mode_ff == tmc_pkg::MODE_IMMEDIATE) ?
                              tmc_pkg::ST_CAPT : tmc_pkg::ST_WAIT;
            end
            tmc_pkg::REQ_STOP: begin
               state_in = tmc_pkg::ST_IDLE;
               count_in = '0;
            end
            tmc_pkg::REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmc_pkg::ST_IDLE;
         count_ff     <= '0;
         prev_trig_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prev_trig_ff <= prev_trig_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (accept) begin
         p_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         p_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_status_ff <= state_in;
         p_count_ff  <= count_in;
         p_rvalid_ff <= is_read && rd_hit;
         p_bank_ff   <= req_read_index[tmc_pkg::BANK_W-1:0];
      end
   end

   // Output: entry fields are zero unless the read hit
   assign rd_sel             = bank_rdata[p_bank_ff];
   assign rsp_valid          = p_valid_ff;
   assign rsp_capture_status = p_status_ff;
   assign rsp_sample_count   = p_count_ff;
   assign rsp_read_valid     = p_rvalid_ff;
   assign rsp_read_channel   = p_rvalid_ff ? rd_sel.chan : '0;
   assign rsp_read_value     = p_rvalid_ff ? rd_sel.value : '0;

endmodule

// ===== hw/rtl/tmc_lane.sv =====
`timescale 1ns / 1ps
// Capture lane: places one channel's sample at its slot in the buffer order.
// Depends on tmc_pkg.
module tmc_lane #(
   parameter int LANE  = 0,
   parameter int CNT_W = 11,
   parameter int IDX_W = 10
) (
   input  logic                              tick_capt,
   input  logic [tmc_pkg::ENABLE_W-1:0]      enable,
   input  logic [CNT_W-1:0]                  count,
   input  logic [CNT_W-1:0]                  room,
   input  logic signed [tmc_pkg::SAMPLE_W-1:0] sample,
   output logic                              wr_valid,
   output logic [IDX_W-1:0]                  wr_addr,
   output tmc_pkg::entry_type                wr_entry
);

   localparam logic [tmc_pkg::ENABLE_W-1:0] LOW_MASK = tmc_pkg::ENABLE_W'((1 << LANE) - 1);

   logic [tmc_pkg::POS_W-1:0] pos;
   logic [CNT_W-1:0]          slot;

   // Position among the enabled channels below this one
   assign pos  = tmc_pkg::POS_W'($countones(enable & LOW_MASK));
   assign slot = count + CNT_W'(pos);

   // Write only while the slot is still under the limit
   assign wr_valid       = tick_capt && enable[LANE] && (CNT_W'(pos) < room);
   assign wr_addr        = slot[IDX_W-1:0];
   assign wr_entry.chan  = tmc_pkg::CHAN_W'(LANE);
   assign wr_entry.value = sample;

endmodule

// ===== hw/rtl/tmc_bank.sv =====
`timescale 1ns / 1ps
// One bank of the capture buffer: one write port, one registered read port.
// Depends on tmc_pkg for the entry type.
module tmc_bank #(
   parameter int ROWS = 256,
   parameter int RW   = 8
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [RW-1:0]      wr_row,
   input  tmc_pkg::entry_type wr_entry,
   input  logic               rd_en,
   input  logic [RW-1:0]      rd_row,
   output tmc_pkg::entry_type rd_entry
);

   tmc_pkg::entry_type mem_ff [ROWS];
   tmc_pkg::entry_type rd_entry_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_entry;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_row];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== hw/rtl/tmc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the triggered multichannel capture top level, and the
// bind that attaches them. Depends on tmc_pkg and triggered_multichannel_capture.
module tmc_checker #(
   parameter int SAMPLE_DEPTH = 1024,
   localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1)
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [tmc_pkg::STATUS_W-1:0]        rsp_capture_status,
   input logic [CNT_W-1:0]                    rsp_sample_count,
   input logic [tmc_pkg::CHAN_W-1:0]          rsp_read_channel,
   input logic signed [tmc_pkg::SAMPLE_W-1:0] rsp_read_value,
   input logic                                rsp_read_valid
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SAMPLE_DEPTH);

   // Stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_capture_status) &&
         $stable(rsp_sample_count) && $stable(rsp_read_channel) &&
         $stable(rsp_read_value) && $stable(rsp_read_valid))
      else $error("response changed while stalled");

   // Entry fields are zero when no entry was returned
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_channel == '0 && rsp_read_value == '0)
      else $error("entry fields set without a valid read");

   // Idle always comes with a zero entry count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_capture_status == tmc_pkg::ST_IDLE |-> rsp_sample_count == '0)
      else $error("idle with nonzero count");

   // Count never passes the buffer depth, and a hit needs a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count <= DEPTH_CNT &&
         (!rsp_read_valid || rsp_sample_count != '0))
      else $error("count out of range");

   // Nothing is presented right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind triggered_multichannel_capture tmc_checker #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_tmc_checker (.*);
